// File: src/hkl_pkg.sv
`timescale 1ns / 1ps
// Shared types and codes for the held key ledger.
// Used by hkl_ctrl, hkl_dp and the top level; depends on nothing.
package hkl_pkg;

	localparam int REQ_W      = 3;
	localparam int SRC_W      = 64;
	localparam int CODE_W     = 16;
	localparam int BTN_W      = 8;
	localparam int IN_DATA_W  = 112;
	localparam int OUT_DATA_W = 112;

	localparam logic [REQ_W-1:0] REQ_KEY    = 3'd0;
	localparam logic [REQ_W-1:0] REQ_MOUSE  = 3'd1;
	localparam logic [REQ_W-1:0] REQ_RETIRE = 3'd2;

	localparam logic KIND_KEY   = 1'b0;
	localparam logic KIND_MOUSE = 1'b1;

	typedef struct packed {
		logic [SRC_W-1:0]  source;
		logic [CODE_W-1:0] scan;
		logic [CODE_W-1:0] keycode;
	} entry_t;

	typedef struct packed {
		logic              kind;
		logic [SRC_W-1:0]  source;
		logic              down;
		logic [CODE_W-1:0] scan;
		logic [CODE_W-1:0] keycode;
		logic [BTN_W-1:0]  buttons;
		logic              last;
	} result_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic idle;
		logic load_req;
		logic next_idx;
		logic rm_slot;
		logic append;
		logic emit_req;
		logic push_pend;
		logic take_pend;
		logic flush_pend;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic [REQ_W-1:0] req_type;
		logic             running;
		logic             idx_lt_cnt;
		logic             match_key;
		logic             match_src;
		logic             can_append;
		logic             out_free;
		logic             pend_valid;
	} status_t;

endpackage

// File: src/hkl_ctrl.sv
`timescale 1ns / 1ps
// Controller for the held key ledger: sequences lookups, removals, appends
// and result emission. Depends on hkl_pkg.
module hkl_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  hkl_pkg::status_t st,
	output hkl_pkg::cmd_t    cmd
);

	typedef enum logic [3:0] {
		S_IDLE,
		S_DISPATCH,
		S_K_RD,
		S_K_CMP,
		S_K_APP,
		S_EMIT,
		S_R_RD,
		S_R_CMP,
		S_R_END
	} state_t;

	state_t state_q, state_d;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			S_IDLE: begin
				cmd.idle = 1'b1;
				if (in_valid) begin
					cmd.load_req = 1'b1;
					state_d      = S_DISPATCH;
				end
			end
			S_DISPATCH: begin
				case (st.req_type)
					hkl_pkg::REQ_KEY:    state_d = S_K_RD;
					hkl_pkg::REQ_MOUSE:  state_d = st.running ? S_EMIT : S_IDLE;
					hkl_pkg::REQ_RETIRE: state_d = S_R_RD;
					default:             state_d = S_IDLE;
				endcase
			end
			S_K_RD: begin
				state_d = st.idx_lt_cnt ? S_K_CMP : S_K_APP;
			end
			S_K_CMP: begin
				if (st.match_key) begin
					cmd.rm_slot = 1'b1;
					state_d     = S_K_APP;
				end else begin
					cmd.next_idx = 1'b1;
					state_d      = S_K_RD;
				end
			end
			S_K_APP: begin
				cmd.append = st.can_append;
				state_d    = st.running ? S_EMIT : S_IDLE;
			end
			S_EMIT: begin
				if (st.out_free) begin
					cmd.emit_req = 1'b1;
					state_d      = S_IDLE;
				end
			end
			S_R_RD: begin
				state_d = st.idx_lt_cnt ? S_R_CMP : S_R_END;
			end
			S_R_CMP: begin
				if (!st.match_src) begin
					cmd.next_idx = 1'b1;
					state_d      = S_R_RD;
				end else if (!st.running) begin
					cmd.rm_slot = 1'b1;
					state_d     = S_R_RD;
				end else if (!st.pend_valid || st.out_free) begin
					// The held-back release goes out now that another one follows it.
					cmd.push_pend = st.pend_valid;
					cmd.take_pend = 1'b1;
					cmd.rm_slot   = 1'b1;
					state_d       = S_R_RD;
				end
			end
			S_R_END: begin
				if (!st.pend_valid) begin
					state_d = S_IDLE;
				end else if (st.out_free) begin
					cmd.flush_pend = 1'b1;
					state_d        = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// File: src/hkl_dp.sv
`timescale 1ns / 1ps
// Datapath for the held key ledger: request register, entry memory, index and
// count, pending release and output register. Depends on hkl_pkg.
module hkl_dp #(
	parameter int LEDGER_DEPTH = 64
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  hkl_pkg::cmd_t                       cmd,
	output hkl_pkg::status_t                    st,
	input  logic [hkl_pkg::REQ_W-1:0]           in_type,
	input  logic [hkl_pkg::IN_DATA_W-1:0]       in_data,
	output logic                                out_valid,
	input  logic                                out_ready,
	output hkl_pkg::result_t                    out_res
);

	localparam int IDX_W = (LEDGER_DEPTH > 1) ? $clog2(LEDGER_DEPTH) : 1;
	localparam int CNT_W = $clog2(LEDGER_DEPTH + 1);

	logic [hkl_pkg::REQ_W-1:0]  req_type_q;
	logic [hkl_pkg::SRC_W-1:0]  req_source_q;
	logic                       req_down_q;
	logic [hkl_pkg::CODE_W-1:0] req_scan_q;
	logic [hkl_pkg::CODE_W-1:0] req_keycode_q;
	logic [hkl_pkg::BTN_W-1:0]  req_buttons_q;
	logic                       req_running_q;

	hkl_pkg::entry_t mem_q [LEDGER_DEPTH];
	hkl_pkg::entry_t rd_a_q, rd_b_q, req_entry;

	logic [CNT_W-1:0] idx_q, cnt_q, cnt_m1;
	hkl_pkg::entry_t  pend_q;
	logic             pend_valid_q;
	hkl_pkg::result_t out_q;
	logic             out_valid_q;
	logic             out_free;

	assign req_entry = '{source: req_source_q, scan: req_scan_q, keycode: req_keycode_q};
	assign cnt_m1    = cnt_q - CNT_W'(1);
	assign out_free  = !out_valid_q || out_ready;

	always_ff @(posedge clk) begin
		if (cmd.load_req) begin
			req_type_q    <= in_type;
			req_source_q  <= in_data[63:0];
			req_down_q    <= in_data[64];
			req_scan_q    <= in_data[80:65];
			req_keycode_q <= in_data[96:81];
			req_buttons_q <= in_data[104:97];
			req_running_q <= in_data[105];
		end
	end

	// Entry memory: one write port, two registered read ports (scan slot and last slot).
	always_ff @(posedge clk) begin
		if (cmd.rm_slot) begin
			mem_q[idx_q[IDX_W-1:0]] <= rd_b_q;
		end else if (cmd.append) begin
			mem_q[cnt_q[IDX_W-1:0]] <= req_entry;
		end
		rd_a_q <= mem_q[idx_q[IDX_W-1:0]];
		rd_b_q <= mem_q[cnt_m1[IDX_W-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q        <= '0;
			cnt_q        <= '0;
			pend_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cmd.load_req) begin
				idx_q <= '0;
			end else if (cmd.next_idx) begin
				idx_q <= idx_q + CNT_W'(1);
			end
			if (cmd.rm_slot) begin
				cnt_q <= cnt_m1;
			end else if (cmd.append) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end
			if (cmd.take_pend) begin
				pend_valid_q <= 1'b1;
			end else if (cmd.flush_pend) begin
				pend_valid_q <= 1'b0;
			end
			if (cmd.emit_req || cmd.push_pend || cmd.flush_pend) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take_pend) begin
			pend_q <= rd_a_q;
		end
		if (cmd.emit_req) begin
			if (req_type_q == hkl_pkg::REQ_MOUSE) begin
				out_q <= '{kind: hkl_pkg::KIND_MOUSE, source: req_source_q, down: 1'b0,
					scan: '0, keycode: '0, buttons: req_buttons_q, last: 1'b1};
			end else begin
				out_q <= '{kind: hkl_pkg::KIND_KEY, source: req_source_q, down: req_down_q,
					scan: req_scan_q, keycode: req_keycode_q, buttons: '0, last: 1'b1};
			end
		end else if (cmd.push_pend || cmd.flush_pend) begin
			out_q <= '{kind: hkl_pkg::KIND_KEY, source: pend_q.source, down: 1'b0,
				scan: pend_q.scan, keycode: pend_q.keycode, buttons: '0,
				last: cmd.flush_pend};
		end
	end

	assign st.req_type   = req_type_q;
	assign st.running    = req_running_q;
	assign st.idx_lt_cnt = idx_q < cnt_q;
	assign st.match_src  = rd_a_q.source == req_source_q;
	assign st.match_key  = (rd_a_q == req_entry);
	assign st.can_append = req_down_q && (cnt_q < CNT_W'(LEDGER_DEPTH));
	assign st.out_free   = out_free;
	assign st.pend_valid = pend_valid_q;

	assign out_valid = out_valid_q;
	assign out_res   = out_q;

endmodule

// File: src/held_key_ledger_with_source_release_unit.sv
`timescale 1ns / 1ps
// Held key ledger with source release: top level joining controller and datapath.
// Depends on hkl_pkg, hkl_ctrl and hkl_dp.
//
// Input words arrive on the s_ group: tuser carries the request type, tdata
// the event fields. A key press or release updates the table of held keys
// and, while the machine runs, is forwarded as one word on the m_ group.
// A mouse event is forwarded while running. A source retirement walks the
// table from slot 0 and removes every entry of that source; while running,
// each removed entry is sent as a key release and the final one has tlast.
// Every forwarded key or mouse word also has tlast set.
// A word is taken and decoded, then the table is walked slot by slot; each slot
// is read and then compared (the entry memory read is registered). A freed
// slot is refilled by the last entry and examined again, so every held entry
// is examined once. One word is handled at a time; s_tready is high only
// between words. Results sit in an output register, so a new word can be
// taken while one waits. When the register is full and m_tready is low, the
// next result waits for it, pausing any walk. Reset empties the table at
// once; no clearing pass is needed.
module held_key_ledger_with_source_release_unit #(
	parameter int LEDGER_DEPTH = 64
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	// tdata: source_id[63:0], key_down[64], scan[80:65], key_code[96:81],
	// mouse_buttons[104:97], machine_running[105], zero fill
	input  logic [hkl_pkg::IN_DATA_W-1:0]     s_tdata,
	// tuser: req_type[2:0]
	input  logic [hkl_pkg::REQ_W-1:0]         s_tuser,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	// tdata: out_source[63:0], out_down[64], out_scan[80:65], out_keycode[96:81],
	// out_buttons[104:97], zero fill
	output logic [hkl_pkg::OUT_DATA_W-1:0]    m_tdata,
	// tuser: out_kind[0]
	output logic                              m_tuser,
	output logic                              m_tlast
);

	hkl_pkg::cmd_t    cmd;
	hkl_pkg::status_t st;
	hkl_pkg::result_t res;

	hkl_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.st       (st),
		.cmd      (cmd)
	);

	hkl_dp #(
		.LEDGER_DEPTH (LEDGER_DEPTH)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.st        (st),
		.in_type   (s_tuser),
		.in_data   (s_tdata),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_res   (res)
	);

	assign s_tready = cmd.idle;
	assign m_tuser  = res.kind;
	assign m_tlast  = res.last;
	assign m_tdata  = {7'd0, res.buttons, res.keycode, res.scan, res.down, res.source};

endmodule

// File: test/tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for held_key_ledger_with_source_release_unit.
// A behavioral ledger predicts every forwarded word; depends on hkl_pkg and the block.
module tb;
	import hkl_pkg::*;

	localparam int LEDGER_DEPTH = 64;
	localparam logic [REQ_W-1:0] REQ_WINDOW_CLOSE = 3'd3;
	localparam logic [REQ_W-1:0] REQ_HOTKEY       = 3'd4;
	localparam logic [REQ_W-1:0] REQ_LAST         = 3'd7;
	localparam int MIXED_PER_PHASE = 50;
	localparam int FILL_PRESSES    = LEDGER_DEPTH + 2;
	localparam int SETTLE_CYCLES   = 300;

	typedef struct {
		logic [REQ_W-1:0]  req;
		logic [SRC_W-1:0]  source;
		logic              down;
		logic [CODE_W-1:0] scan;
		logic [CODE_W-1:0] keycode;
		logic [BTN_W-1:0]  buttons;
		logic              running;
	} key_event_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata = '0;
	logic [REQ_W-1:0]      s_tuser = '0;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_tdata;
	logic                  m_tuser;
	logic                  m_tlast;

	held_key_ledger_with_source_release_unit #(
		.LEDGER_DEPTH(LEDGER_DEPTH)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.m_tlast(m_tlast)
	);

	// Predicted ledger contents.
	logic [SRC_W-1:0]  held_src [LEDGER_DEPTH];
	logic [CODE_W-1:0] held_scan [LEDGER_DEPTH];
	logic [CODE_W-1:0] held_keycode [LEDGER_DEPTH];
	int                held_count = 0;

	key_event_t        pending_events[$];
	key_event_t        driven_event;
	result_t           expected_words[$];
	int                failures = 0;
	int                sender_idle_pct = 0;
	int                receiver_stall_pct = 0;
	logic [SRC_W-1:0]  source_pool [4];
	logic [CODE_W-1:0] code_pool [4] = '{16'h0000, 16'hFFFF, 16'h0004, 16'h001E};

	initial begin
		forever #5 clk = ~clk;
	end

	// Freeing a slot moves the last entry into it.
	function automatic void drop_held(input int slot);
		held_count--;
		held_src[slot] = held_src[held_count];
		held_scan[slot] = held_scan[held_count];
		held_keycode[slot] = held_keycode[held_count];
	endfunction

	function automatic void predict_event(input key_event_t ev);
		result_t produced[$];
		result_t r;
		int      slot;
		r = '0;
		case (ev.req)
			REQ_KEY: begin
				for (int i = 0; i < held_count; i++) begin
					if (held_src[i] == ev.source && held_scan[i] == ev.scan &&
							held_keycode[i] == ev.keycode) begin
						drop_held(i);
						break;
					end
				end
				if (ev.down && held_count < LEDGER_DEPTH) begin
					held_src[held_count] = ev.source;
					held_scan[held_count] = ev.scan;
					held_keycode[held_count] = ev.keycode;
					held_count++;
				end
				if (ev.running) begin
					r.kind = KIND_KEY;
					r.source = ev.source;
					r.down = ev.down;
					r.scan = ev.scan;
					r.keycode = ev.keycode;
					produced.push_back(r);
				end
			end
			REQ_MOUSE: begin
				if (ev.running) begin
					r.kind = KIND_MOUSE;
					r.source = ev.source;
					r.buttons = ev.buttons;
					produced.push_back(r);
				end
			end
			REQ_RETIRE: begin
				slot = 0;
				// A filled slot holds a different entry now, so it is examined again.
				while (slot < held_count) begin
					if (held_src[slot] != ev.source) begin
						slot++;
					end else begin
						if (ev.running) begin
							r = '0;
							r.kind = KIND_KEY;
							r.source = held_src[slot];
							r.scan = held_scan[slot];
							r.keycode = held_keycode[slot];
							produced.push_back(r);
						end
						drop_held(slot);
					end
				end
			end
			default: begin
			end
		endcase
		if (produced.size() != 0)
			produced[produced.size()-1].last = 1'b1;
		foreach (produced[i])
			expected_words.push_back(produced[i]);
	endfunction

	// Word driver: holds the current word until accepted, then takes the next one.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
			s_tuser <= '0;
		end else begin
			if (s_tvalid && s_tready)
				predict_event(driven_event);
			if (!s_tvalid || s_tready) begin
				if (pending_events.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
					driven_event = pending_events.pop_front();
					s_tvalid <= 1'b1;
					s_tdata <= IN_DATA_W'({driven_event.running, driven_event.buttons,
						driven_event.keycode, driven_event.scan, driven_event.down,
						driven_event.source});
					s_tuser <= driven_event.req;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= receiver_stall_pct);
		end
	end

	task automatic compare_field(input string name, input logic [63:0] expv,
			input logic [63:0] actv);
		if (actv !== expv) begin
			$error("%s: expected %h, got %h", name, expv, actv);
			failures++;
		end
	endtask

	// Result monitor.
	always @(posedge clk) begin
		result_t oldest;
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_words.size() == 0) begin
				$error("unexpected word: tuser %h tdata %h tlast %b", m_tuser, m_tdata, m_tlast);
				failures++;
			end else begin
				oldest = expected_words.pop_front();
				compare_field("out_kind", 64'(oldest.kind), 64'(m_tuser));
				compare_field("out_source", oldest.source, m_tdata[63:0]);
				compare_field("out_down", 64'(oldest.down), 64'(m_tdata[64]));
				compare_field("out_scan", 64'(oldest.scan), 64'(m_tdata[80:65]));
				compare_field("out_keycode", 64'(oldest.keycode), 64'(m_tdata[96:81]));
				compare_field("out_buttons", 64'(oldest.buttons), 64'(m_tdata[104:97]));
				compare_field("last", 64'(oldest.last), 64'(m_tlast));
			end
		end
	end

	function automatic key_event_t make_event(input logic [REQ_W-1:0] req,
			input logic [SRC_W-1:0] src, input logic down, input logic [CODE_W-1:0] scan,
			input logic [CODE_W-1:0] kc, input logic [BTN_W-1:0] btn, input logic run);
		key_event_t ev;
		ev.req = req;
		ev.source = src;
		ev.down = down;
		ev.scan = scan;
		ev.keycode = kc;
		ev.buttons = btn;
		ev.running = run;
		return ev;
	endfunction

	function automatic logic [SRC_W-1:0] pick_source();
		if ($urandom_range(99) < 5)
			return {$urandom, $urandom};
		return source_pool[$urandom_range(3)];
	endfunction

	// Mostly a handful of codes so presses and releases meet each other.
	function automatic logic [CODE_W-1:0] pick_code();
		if ($urandom_range(99) < 15)
			return CODE_W'($urandom);
		return code_pool[$urandom_range(3)];
	endfunction

	function automatic logic pick_running();
		return $urandom_range(99) < 80;
	endfunction

	function automatic key_event_t random_event();
		int roll;
		roll = $urandom_range(99);
		if (roll < 70)
			return make_event(REQ_KEY, pick_source(), roll < 45, pick_code(), pick_code(),
				BTN_W'($urandom), pick_running());
		if (roll < 80)
			return make_event(REQ_MOUSE, pick_source(), 1'($urandom), CODE_W'($urandom),
				CODE_W'($urandom), BTN_W'($urandom), pick_running());
		if (roll < 92)
			return make_event(REQ_RETIRE, pick_source(), 1'($urandom), CODE_W'($urandom),
				CODE_W'($urandom), BTN_W'($urandom), pick_running());
		return make_event(REQ_W'($urandom_range(REQ_LAST, REQ_WINDOW_CLOSE)), pick_source(),
			1'($urandom), CODE_W'($urandom), CODE_W'($urandom), BTN_W'($urandom),
			pick_running());
	endfunction

	// Retire every pool source, fill the ledger past capacity from one source, then retire that source.
	task automatic queue_fill_and_retire(input logic [SRC_W-1:0] src);
		foreach (source_pool[i])
			pending_events.push_back(make_event(REQ_RETIRE, source_pool[i], 1'b0, '0, '0,
				'0, pick_running()));
		for (int i = 0; i < FILL_PRESSES; i++)
			pending_events.push_back(make_event(REQ_KEY, src, 1'b1, CODE_W'(i), pick_code(),
				BTN_W'($urandom), $urandom_range(99) < 85));
		pending_events.push_back(make_event(REQ_RETIRE, src, 1'b0, '0, '0, '0, 1'b1));
	endtask

	task automatic wait_sent();
		while (pending_events.size() != 0 || s_tvalid)
			@(negedge clk);
	endtask

	task automatic wait_results();
		while (expected_words.size() != 0)
			@(negedge clk);
	endtask

	initial begin
		int idle_pct [4];
		int stall_pct [4];
		idle_pct = '{0, 51, 0, 27};
		stall_pct = '{0, 0, 51, 27};
		source_pool[0] = '0;
		source_pool[1] = '1;
		source_pool[2] = 64'h5555_5555_AAAA_AAAA;
		source_pool[3] = {$urandom, $urandom};
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed part: field extremes, repeated presses, unmatched releases, ignored
		// requests, paused machine and retirements with zero, silent and several releases.
		pending_events.push_back(make_event(REQ_KEY, source_pool[0], 1'b1, 16'h0000,
			16'h0000, 8'h00, 1'b1));
		pending_events.push_back(make_event(REQ_KEY, source_pool[1], 1'b1, 16'hFFFF,
			16'hFFFF, 8'hFF, 1'b1));
		pending_events.push_back(make_event(REQ_KEY, source_pool[1], 1'b1, 16'hFFFF,
			16'hFFFF, 8'h00, 1'b1));
		pending_events.push_back(make_event(REQ_KEY, source_pool[1], 1'b0, 16'hFFFF,
			16'hFFFF, 8'h00, 1'b1));
		pending_events.push_back(make_event(REQ_KEY, source_pool[1], 1'b0, 16'h1234,
			16'h5678, 8'h00, 1'b1));
		pending_events.push_back(make_event(REQ_MOUSE, source_pool[1], 1'b1, 16'hFFFF,
			16'hFFFF, 8'hFF, 1'b1));
		pending_events.push_back(make_event(REQ_MOUSE, source_pool[0], 1'b0, 16'h0000,
			16'h0000, 8'hA5, 1'b0));
		pending_events.push_back(make_event(REQ_KEY, source_pool[2], 1'b1, 16'hAAAA,
			16'h5555, 8'h00, 1'b0));
		pending_events.push_back(make_event(REQ_KEY, source_pool[2], 1'b0, 16'hAAAA,
			16'h5555, 8'h00, 1'b0));
		pending_events.push_back(make_event(REQ_KEY, source_pool[2], 1'b1, 16'hAAAA,
			16'h5555, 8'h00, 1'b0));
		for (int r = REQ_WINDOW_CLOSE; r <= REQ_LAST; r++)
			pending_events.push_back(make_event(REQ_W'(r), source_pool[2], 1'($urandom),
				CODE_W'($urandom), CODE_W'($urandom), BTN_W'($urandom), 1'b1));
		pending_events.push_back(make_event(REQ_RETIRE, {$urandom, $urandom}, 1'b0,
			16'h0000, 16'h0000, 8'h00, 1'b1));
		pending_events.push_back(make_event(REQ_KEY, source_pool[3], 1'b1, 16'h0001,
			16'h0002, 8'h00, 1'b1));
		pending_events.push_back(make_event(REQ_KEY, source_pool[3], 1'b1, 16'h0003,
			16'h0004, 8'h00, 1'b1));
		pending_events.push_back(make_event(REQ_KEY, source_pool[0], 1'b1, 16'h0005,
			16'h0006, 8'h00, 1'b1));
		pending_events.push_back(make_event(REQ_KEY, source_pool[3], 1'b1, 16'h0007,
			16'h0008, 8'h00, 1'b1));
		pending_events.push_back(make_event(REQ_RETIRE, source_pool[3], 1'b0, 16'h0000,
			16'h0000, 8'h00, 1'b1));
		pending_events.push_back(make_event(REQ_RETIRE, source_pool[2], 1'b0, 16'h0000,
			16'h0000, 8'h00, 1'b0));
		pending_events.push_back(make_event(REQ_RETIRE, source_pool[0], 1'b0, 16'h0000,
			16'h0000, 8'h00, 1'b1));
		wait_sent();
		// Hold off new words until every forwarded word is back.
		wait_results();

		for (int phase = 0; phase < 4; phase++) begin
			sender_idle_pct = idle_pct[phase];
			receiver_stall_pct = stall_pct[phase];
			if (phase >= 2)
				queue_fill_and_retire(source_pool[$urandom_range(3)]);
			repeat (MIXED_PER_PHASE)
				pending_events.push_back(random_event());
			wait_sent();
		end

		wait_results();
		repeat (SETTLE_CYCLES) @(negedge clk);
		if (failures == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

	initial begin
		#20_000_000;
		$display("Test completed with failures");
		$finish;
	end

endmodule
